@@ rtl/lz77_greedy_factorizer_top_macros.svh @@
// Assertion macros used by the checker file of the LZ77 factoriser.
// Holds macros only; no dependencies.
`ifndef LZ77_GREEDY_FACTORIZER_TOP_MACROS_SVH
`define LZ77_GREEDY_FACTORIZER_TOP_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define LZF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define LZF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

@@ rtl/lzf_pkg.sv @@
// Package of the LZ77 factoriser: operation codes, widths and controller types.
// No dependencies.
`default_nettype none
package lzf_pkg;
    localparam int MAX_LEN_DEF = 4096;
    localparam int OP_W = 2;
    localparam logic [OP_W-1:0] OP_APPEND  = 2'd0;
    localparam logic [OP_W-1:0] OP_REQUEST = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR   = 2'd2;
    localparam int LEN_W = 13;
    localparam int START_W = 12;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic append;
        logic clear;
        logic scan_init;  // begin a request: s = 0, n = 0, best = 0
        logic step;       // one scan step: issue reads or compare
        logic finish;     // commit token, move cursor
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic has_work;   // cursor below stored length
        logic scan_done;  // all starts examined
    } t_stat;
endpackage
`default_nettype wire

@@ rtl/lzf_ctrl.sv @@
// Controller state machine of the LZ77 factoriser.
// Depends on lzf_pkg.
`default_nettype none
module lzf_ctrl
    import lzf_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_start,
    input  wire logic [OP_W-1:0] i_operation,
    input  wire t_stat           i_stat,
    output t_cmd                 o_cmd,
    output logic                 o_busy,
    output logic                 o_valid
);
    localparam logic [1:0] S_IDLE = 2'd0, S_CHECK = 2'd1, S_SCAN = 2'd2, S_DONE = 2'd3;
    logic [1:0] r_state, n_state;
    logic       r_valid;

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    case (i_operation)
                        OP_APPEND: o_cmd.append = 1'b1;
                        OP_CLEAR:  o_cmd.clear = 1'b1;
                        OP_REQUEST: begin
                            o_cmd.scan_init = 1'b1;
                            n_state = S_CHECK;
                        end
                        default: ;
                    endcase
                end
            end
            S_CHECK: n_state = i_stat.has_work ? S_SCAN : S_IDLE;
            S_SCAN: begin
                if (i_stat.scan_done) n_state = S_DONE;
                else o_cmd.step = 1'b1;
            end
            S_DONE: begin
                o_cmd.finish = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= o_cmd.finish;
        end
    end

    assign o_busy = (r_state != S_IDLE) || r_valid;
    assign o_valid = r_valid;
endmodule
`default_nettype wire

@@ rtl/lzf_datapath.sv @@
// Datapath of the LZ77 factoriser: byte memory, cursor, scan counters, best match.
// Depends on lzf_pkg.
`default_nettype none
module lzf_datapath
    import lzf_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_cmd             i_cmd,
    input  wire logic [7:0]       i_data_byte,
    output t_stat                 o_stat,
    output logic                  o_is_literal,
    output logic [LEN_W-1:0]      o_match_length,
    output logic [START_W-1:0]    o_match_start,
    output logic [7:0]            o_literal_byte,
    output logic                  o_final_token
);
    localparam int AW = $clog2(MAX_LEN);
    localparam int CW = $clog2(MAX_LEN + 1);

    logic [7:0] r_mem [MAX_LEN];
    logic [CW-1:0] r_len, r_cur;
    // Scan state: candidate s, offset n, phase (0 issue reads, 1 compare).
    logic [CW-1:0] r_s, r_n, r_best_len, r_best_s;
    logic          r_phase;
    logic [7:0]    r_rd_a, r_rd_b;
    logic [CW-1:0] a_idx, b_idx, a_pos, b_pos;

    assign a_pos = r_s + r_n;
    assign b_pos = r_cur + r_n;
    assign a_idx = a_pos;
    assign b_idx = b_pos;

    // Two read ports, registered data.
    always_ff @(posedge i_clk) begin
        if (i_cmd.append && (r_len < CW'(MAX_LEN))) r_mem[r_len[AW-1:0]] <= i_data_byte;
        r_rd_a <= r_mem[a_idx[AW-1:0]];
        r_rd_b <= r_mem[b_idx[AW-1:0]];
    end

    logic in_range, extend;
    assign in_range = b_pos < r_len;
    assign extend = in_range && (r_rd_a == r_rd_b);
    assign o_stat.has_work = r_cur < r_len;
    assign o_stat.scan_done = (r_s >= r_cur);

    logic [CW-1:0] adv;
    assign adv = (r_best_len != '0) ? r_best_len : CW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
            r_cur <= '0;
        end else begin
            if (i_cmd.append && (r_len < CW'(MAX_LEN))) r_len <= r_len + CW'(1);
            if (i_cmd.clear) begin
                r_len <= '0;
                r_cur <= '0;
            end
            if (i_cmd.finish) r_cur <= r_cur + adv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_init) begin
            r_s <= '0;
            r_n <= '0;
            r_phase <= 1'b0;
            r_best_len <= '0;
            r_best_s <= '0;
        end else if (i_cmd.step) begin
            if (!r_phase) begin
                r_phase <= 1'b1;
            end else if (extend) begin
                r_n <= r_n + CW'(1);
                r_phase <= 1'b0;
            end else begin
                if (r_n > r_best_len) begin
                    r_best_len <= r_n;
                    r_best_s <= r_s;
                end
                r_s <= r_s + CW'(1);
                r_n <= '0;
                r_phase <= 1'b0;
            end
        end
        // Once the scan is over n is back at zero, so the second read port has
        // held the byte at the cursor since the cycle before the finish.
        if (i_cmd.finish) begin
            o_is_literal   <= (r_best_len == '0);
            o_match_length <= LEN_W'(r_best_len);
            o_match_start  <= (r_best_len == '0) ? '0 : START_W'(r_best_s);
            o_literal_byte <= (r_best_len == '0) ? r_rd_b : 8'd0;
            o_final_token  <= (r_cur + adv) >= r_len;
        end
    end
endmodule
`default_nettype wire

@@ rtl/lz77_greedy_factorizer_top.sv @@
// Top level of the greedy LZ77 factoriser; depends on lzf_pkg, lzf_ctrl, lzf_datapath.
// Append and clear give no beat, nor does a request with nothing left to parse.
// A request's result beat follows a scan with one compare per earlier start plus one
// per matched byte; no new command is taken until that beat has been shown.
// The receiver cannot stall: each result beat lasts one cycle. Synchronous reset
// empties the buffer and cursor; buffer contents are undefined until written.
`default_nettype none
module lz77_greedy_factorizer_top
    import lzf_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [OP_W-1:0]    i_operation,
    input  wire logic [7:0]         i_data_byte,
    output logic                    o_valid,
    output logic                    o_is_literal,
    output logic [LEN_W-1:0]        o_match_length,
    output logic [START_W-1:0]      o_match_start,
    output logic [7:0]              o_literal_byte,
    output logic                    o_final_token
);
    t_cmd  cmd;
    t_stat stat;
    logic  accept;

    // An item is taken only when the block is not busy.
    assign accept = start && !busy;

    lzf_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(accept), .i_operation(i_operation),
        .i_stat(stat), .o_cmd(cmd), .o_busy(busy), .o_valid(o_valid)
    );

    lzf_datapath #(.MAX_LEN(MAX_LEN)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .i_data_byte(i_data_byte),
        .o_stat(stat), .o_is_literal(o_is_literal), .o_match_length(o_match_length),
        .o_match_start(o_match_start), .o_literal_byte(o_literal_byte),
        .o_final_token(o_final_token)
    );
endmodule
`default_nettype wire

@@ rtl/lzf_checker.sv @@
// Port-level checker of the LZ77 factoriser, bound to the top level.
// Depends on lzf_pkg and the assertion macro header.
`default_nettype none
`include "lz77_greedy_factorizer_top_macros.svh"
module lzf_checker
    import lzf_pkg::*;
(
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               start,
    input wire logic               busy,
    input wire logic [OP_W-1:0]    i_operation,
    input wire logic               o_valid,
    input wire logic               o_is_literal,
    input wire logic [LEN_W-1:0]   o_match_length,
    input wire logic [7:0]         o_literal_byte
);
    `LZF_ASSERT_IMP(a_valid_busy, i_clk, i_rst_n, o_valid, busy)
    `LZF_ASSERT_NEXT(a_req_busy, i_clk, i_rst_n, start && !busy && i_operation == OP_REQUEST, busy)
    `LZF_ASSERT_NEXT(a_single, i_clk, i_rst_n, o_valid, !o_valid)
    `LZF_ASSERT_IMP(a_lit_len, i_clk, i_rst_n, o_valid && o_is_literal, o_match_length == '0)
    `LZF_ASSERT_IMP(a_match_byte, i_clk, i_rst_n, o_valid && !o_is_literal, o_literal_byte == 8'd0)
endmodule

bind lz77_greedy_factorizer_top lzf_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
    .i_operation(i_operation), .o_valid(o_valid), .o_is_literal(o_is_literal),
    .o_match_length(o_match_length), .o_literal_byte(o_literal_byte)
);
`default_nettype wire

@@ sim/tb.sv @@
// Self-checking bench for the greedy LZ77 factoriser: directed and random command beats.
// Depends on lzf_pkg and lz77_greedy_factorizer_top; tokens are predicted inside the bench.
`timescale 1ns / 100ps
`default_nettype none
module tb;
    import lzf_pkg::*;

    localparam int BUF_DEPTH  = 4096;
    localparam int STALL_LIMIT = 50000;
    // Operation code that the block must ignore.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct {
        logic [OP_W-1:0] op;
        logic [7:0]      data;
    } t_cmd_beat;

    typedef struct {
        logic              lit;
        logic [LEN_W-1:0]  len;
        logic [START_W-1:0] pos;
        logic [7:0]        byte_val;
        logic              fin;
    } t_token;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [OP_W-1:0]    i_operation;
    logic [7:0]         i_data_byte;
    logic               o_valid;
    logic               o_is_literal;
    logic [LEN_W-1:0]   o_match_length;
    logic [START_W-1:0] o_match_start;
    logic [7:0]         o_literal_byte;
    logic               o_final_token;

    lz77_greedy_factorizer_top i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_operation    (i_operation),
        .i_data_byte    (i_data_byte),
        .o_valid        (o_valid),
        .o_is_literal   (o_is_literal),
        .o_match_length (o_match_length),
        .o_match_start  (o_match_start),
        .o_literal_byte (o_literal_byte),
        .o_final_token  (o_final_token)
    );

    // Commands still to be sent, and tokens predicted but not yet seen.
    t_cmd_beat cmd_queue[$];
    t_token    tokens_due[$];

    // Shadow copy of the text buffer, its fill level and the parse cursor.
    logic [7:0] text_mem[BUF_DEPTH];
    int         text_len;
    int         parse_pos;

    int  send_idle_pct;
    bit  beat_taken;
    bit  failed;
    int  quiet_cycles;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Works out the effect of one accepted command beat on the shadow state and,
    // for a request with text left to parse, queues the token it must yield.
    task automatic parse_command(input t_cmd_beat cmd);
        int     best_len;
        int     best_pos;
        int     n;
        t_token tok;
        best_len = 0;
        best_pos = 0;
        case (cmd.op)
            OP_APPEND: begin
                if (text_len < BUF_DEPTH) begin
                    text_mem[text_len] = cmd.data;
                    text_len++;
                end
            end
            OP_CLEAR: begin
                text_len  = 0;
                parse_pos = 0;
            end
            OP_REQUEST: begin
                if (parse_pos < text_len) begin
                    // Every earlier start is tried; the match may run over the cursor.
                    for (int s = 0; s < parse_pos; s++) begin
                        n = 0;
                        while (parse_pos + n < text_len &&
                               text_mem[s + n] == text_mem[parse_pos + n])
                            n++;
                        if (n > best_len) begin
                            best_len = n;
                            best_pos = s;
                        end
                    end
                    if (best_len > 0) begin
                        tok.lit      = 1'b0;
                        tok.len      = best_len[LEN_W-1:0];
                        tok.pos      = best_pos[START_W-1:0];
                        tok.byte_val = 8'd0;
                        parse_pos += best_len;
                    end else begin
                        tok.lit      = 1'b1;
                        tok.len      = '0;
                        tok.pos      = '0;
                        tok.byte_val = text_mem[parse_pos];
                        parse_pos += 1;
                    end
                    tok.fin = (parse_pos >= text_len);
                    tokens_due.push_back(tok);
                end
            end
            default: ;
        endcase
    endtask

    task automatic queue_cmd(input logic [OP_W-1:0] op, input logic [7:0] data);
        t_cmd_beat c;
        c.op   = op;
        c.data = data;
        cmd_queue.push_back(c);
    endtask

    // A string drawn from a small alphabet so that repeats, and hence matches,
    // are common; it is then parsed, sometimes with extra bytes appended midway.
    task automatic queue_random_text(inout int budget);
        int         len;
        int         alpha;
        logic [7:0] base;
        len   = $urandom_range(1, 24);
        alpha = $urandom_range(1, 4);
        base  = 8'($urandom);
        queue_cmd(OP_CLEAR, 8'($urandom));
        for (int i = 0; i < len; i++)
            queue_cmd(OP_APPEND, base + 8'($urandom_range(0, alpha - 1)));
        for (int i = 0; i < len + 2; i++) begin
            case ($urandom_range(0, 19))
                0: queue_cmd(OP_APPEND, base + 8'($urandom_range(0, alpha)));
                1: queue_cmd(OP_UNUSED, 8'($urandom));
                2: queue_cmd(OP_APPEND, 8'($urandom));
                default: queue_cmd(OP_REQUEST, 8'($urandom));
            endcase
        end
        budget -= 2 * len + 3;
    endtask

    // Blocks until every command has been sent and every token has come back.
    task automatic drain;
        do @(posedge i_clk);
        while (cmd_queue.size() != 0 || (start && !beat_taken) || busy ||
               tokens_due.size() != 0);
    endtask

    // Driver: a beat is held on the ports until it has been accepted.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!(start && !beat_taken)) begin
            if (cmd_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                t_cmd_beat c;
                c = cmd_queue.pop_front();
                i_operation <= c.op;
                i_data_byte <= c.data;
                start       <= 1'b1;
                beat_taken  = 1'b0;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor and acceptance: results are checked first, then the beat that
    // the block takes at this edge is fed to the predictor.
    always @(posedge i_clk) begin
        bit progress;
        progress = 1'b0;
        if (i_rst_n) begin
            if (o_valid) begin
                progress = 1'b1;
                if (tokens_due.size() == 0) begin
                    $display("%0t: token with none expected: lit=%0d len=%0d pos=%0d byte=%0d fin=%0d",
                             $time, o_is_literal, o_match_length, o_match_start,
                             o_literal_byte, o_final_token);
                    failed = 1'b1;
                end else begin
                    t_token e;
                    e = tokens_due.pop_front();
                    if (o_is_literal !== e.lit || o_match_length !== e.len ||
                        o_match_start !== e.pos || o_literal_byte !== e.byte_val ||
                        o_final_token !== e.fin) begin
                        $display("%0t: token mismatch, expected lit=%0d len=%0d pos=%0d byte=%0d fin=%0d",
                                 $time, e.lit, e.len, e.pos, e.byte_val, e.fin);
                        $display("%0t:                 actual lit=%0d len=%0d pos=%0d byte=%0d fin=%0d",
                                 $time, o_is_literal, o_match_length, o_match_start,
                                 o_literal_byte, o_final_token);
                        failed = 1'b1;
                    end
                end
            end
            if (start && !busy && !beat_taken) begin
                t_cmd_beat c;
                c.op   = i_operation;
                c.data = i_data_byte;
                parse_command(c);
                beat_taken = 1'b1;
                progress   = 1'b1;
            end
            // Watchdog: too long without any beat moving in either direction.
            quiet_cycles = progress ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial begin
        int budget;
        start         = 1'b0;
        i_operation   = OP_APPEND;
        i_data_byte   = 8'd0;
        i_rst_n       = 1'b0;
        text_len      = 0;
        parse_pos     = 0;
        beat_taken    = 1'b1;
        failed        = 1'b0;
        quiet_cycles  = 0;
        send_idle_pct = 17;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: a request on an empty buffer, the unused code, extreme
        // bytes, an overlapping match, ties to the earliest start, and a parse
        // that is extended by appends after some tokens.
        queue_cmd(OP_REQUEST, 8'h00);
        queue_cmd(OP_UNUSED, 8'hFF);
        queue_cmd(OP_APPEND, 8'h00);
        queue_cmd(OP_APPEND, 8'hFF);
        queue_cmd(OP_APPEND, 8'h00);
        queue_cmd(OP_APPEND, 8'hFF);
        queue_cmd(OP_APPEND, 8'h00);
        repeat (4) queue_cmd(OP_REQUEST, 8'h00);
        queue_cmd(OP_REQUEST, 8'hFF);
        queue_cmd(OP_APPEND, 8'hFF);
        queue_cmd(OP_APPEND, 8'h5A);
        repeat (3) queue_cmd(OP_REQUEST, 8'h00);
        queue_cmd(OP_CLEAR, 8'hA5);
        queue_cmd(OP_APPEND, 8'h61);
        queue_cmd(OP_APPEND, 8'h61);
        queue_cmd(OP_APPEND, 8'h61);
        repeat (3) queue_cmd(OP_REQUEST, 8'h00);

        budget = 35;
        while (budget > 0) queue_random_text(budget);
        drain();

        send_idle_pct = 62;
        budget = 25;
        while (budget > 0) queue_random_text(budget);
        drain();

        send_idle_pct = 0;
        budget = 20;
        while (budget > 0) queue_random_text(budget);
        drain();

        repeat (50) @(posedge i_clk);
        if (!failed)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
`default_nettype wire

@@ sim.f @@
+incdir+rtl
rtl/lzf_pkg.sv
rtl/lzf_ctrl.sv
rtl/lzf_datapath.sv
rtl/lz77_greedy_factorizer_top.sv
rtl/lzf_checker.sv
sim/tb.sv
